FILE: rtl/touch_key_event_qualifier_top_assert.svh
// Assertion macros for the touch key event qualifier RTL (included by tkeq_back).
`ifndef TOUCH_KEY_EVENT_QUALIFIER_TOP_ASSERT_SVH
`define TOUCH_KEY_EVENT_QUALIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TKEQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tkeq assertion failed");

// Next-cycle implication, disabled during reset.
`define TKEQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkeq assertion failed");

`endif

FILE: rtl/tkeq_pkg.sv
// Types and constants of the touch key event qualifier.
package tkeq_pkg;

  // Event mask bits, in emission order
  localparam int EVT_K4 = 0;
  localparam int EVT_K2 = 1;
  localparam int EVT_K3 = 2;
  localparam int EVT_K6 = 3;
  localparam int EVT_W  = 4;

  typedef logic [EVT_W-1:0] evt_mask_t;

  typedef struct packed {
    logic      valid;
    evt_mask_t mask;
  } evt_req_t;

  localparam logic [2:0] KEY_CODE_2 = 3'd2;
  localparam logic [2:0] KEY_CODE_3 = 3'd3;
  localparam logic [2:0] KEY_CODE_4 = 3'd4;
  localparam logic [2:0] KEY_CODE_6 = 3'd6;

  localparam logic [7:0] STATUS_OK_HI = 8'd192;
  localparam logic [7:0] STATUS_OK_LO = 8'd128;

  // Register map
  localparam int         CFG_ADDR_W      = 3;
  localparam logic       REG_SHIELD      = 1'b0;
  localparam logic       REG_CONFIRM     = 1'b1;
  localparam logic [15:0] SHIELD_RESET   = 16'd100;
  localparam logic [15:0] CONFIRM_RESET  = 16'd200;

endpackage

FILE: rtl/tkeq_front.sv
// Poll front end: edge detection, key four qualification and event classification.
module tkeq_front import tkeq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [31:0] now_ms,
  input  logic        key_ban,
  input  logic [7:0]  status_a,
  input  logic [7:0]  keys_a,
  input  logic [7:0]  status_b,
  input  logic [7:0]  keys_b,
  input  logic [7:0]  status_c,
  input  logic [7:0]  keys_c,
  input  logic [15:0] shield_ms,
  input  logic [15:0] confirm_delay_ms,
  output evt_req_t    push
);

  logic [5:0]  prior_touch_bits;
  logic [31:0] shield_until;
  logic [31:0] pending_since;
  logic        key_four_pending;

  logic [5:0]  prior_touch_bits_next;
  logic [31:0] shield_until_next;
  logic [31:0] pending_since_next;
  logic        key_four_pending_next;

  logic [31:0] elapsed;
  logic        confirm_due;
  logic        shielded_old;
  logic        shielded_new;
  logic [32:0] shield_sum;
  logic [5:0]  cur;
  logic [5:0]  rise;
  logic        k23;
  logic        pend_after_confirm;
  evt_mask_t   mask;

  function automatic logic [1:0] chip_bits(input logic [7:0] status, input logic [7:0] keys,
                                           input logic [1:0] old2);
    if (status == STATUS_OK_HI || status == STATUS_OK_LO) begin
      return keys[1:0];
    end
    return old2;
  endfunction

  always_comb begin
    elapsed            = now_ms - pending_since;
    confirm_due        = key_four_pending && (elapsed > {16'd0, confirm_delay_ms});
    shielded_old       = shield_until > now_ms;
    pend_after_confirm = key_four_pending && !confirm_due;

    cur  = {chip_bits(status_c, keys_c, prior_touch_bits[5:4]),
            chip_bits(status_b, keys_b, prior_touch_bits[3:2]),
            chip_bits(status_a, keys_a, prior_touch_bits[1:0])};
    rise = cur & ~prior_touch_bits;
    k23  = rise[4] | rise[0];

    // now + shield lies above now unless it wraps or the window is empty
    shield_sum   = {1'b0, now_ms} + {17'd0, shield_ms};
    shielded_new = k23 ? (!shield_sum[32] && (shield_ms != 16'd0)) : shielded_old;

    mask          = '0;
    mask[EVT_K4]  = confirm_due && !shielded_old;
    mask[EVT_K2]  = rise[4];
    mask[EVT_K3]  = rise[0];
    mask[EVT_K6]  = rise[3];

    prior_touch_bits_next = cur;
    shield_until_next     = k23 ? shield_sum[31:0] : shield_until;
    pending_since_next    = pending_since;
    key_four_pending_next = k23 ? 1'b0 : pend_after_confirm;
    if (rise[1] && !shielded_new) begin
      pending_since_next    = now_ms;
      key_four_pending_next = 1'b1;
    end

    push.valid = accept && !key_ban && (mask != '0);
    push.mask  = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_touch_bits <= '0;
      shield_until     <= '0;
      pending_since    <= '0;
      key_four_pending <= 1'b0;
    end else if (accept && !key_ban) begin
      prior_touch_bits <= prior_touch_bits_next;
      shield_until     <= shield_until_next;
      pending_since    <= pending_since_next;
      key_four_pending <= key_four_pending_next;
    end
  end

endmodule

FILE: rtl/tkeq_fifo.sv
// Short request queue between the front end and the event serialiser.
module tkeq_fifo import tkeq_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  evt_req_t push,
  input  logic     pop,
  output evt_req_t head,
  output logic     full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_mask_t        mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = count != '0;
  assign head.mask  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/tkeq_back.sv
// Event serialiser: emits one key code per cycle from each queued request while m_tready does not stall it.
module tkeq_back import tkeq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  evt_req_t   head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] key_code, [7:3] zero
  output logic       m_tlast    // last_event
);

`include "touch_key_event_qualifier_top_assert.svh"

  evt_mask_t  work;
  evt_mask_t  src;
  evt_mask_t  rem;
  logic [2:0] code_next;
  logic       can_load;
  logic       load;
  logic [2:0] key_code;

  always_comb begin
    src       = (work != '0) ? work : (head.valid ? head.mask : '0);
    rem       = src;
    code_next = KEY_CODE_4;
    if (src[EVT_K4]) begin
      code_next   = KEY_CODE_4;
      rem[EVT_K4] = 1'b0;
    end else if (src[EVT_K2]) begin
      code_next   = KEY_CODE_2;
      rem[EVT_K2] = 1'b0;
    end else if (src[EVT_K3]) begin
      code_next   = KEY_CODE_3;
      rem[EVT_K3] = 1'b0;
    end else begin
      code_next   = KEY_CODE_6;
      rem[EVT_K6] = 1'b0;
    end
    can_load = !m_tvalid || m_tready;
    load     = can_load && (src != '0);
    // take the queue head only once the current request is spent
    pop      = load && (work == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        work <= rem;
      end
      if (can_load) begin
        m_tvalid <= src != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_code <= code_next;
      m_tlast  <= rem == '0;
    end
  end

  assign m_tdata = {5'd0, key_code};

  `TKEQ_ASSERT_IMP(a_code_known, clk, rst, m_tvalid, (key_code == KEY_CODE_2 || key_code == KEY_CODE_3 || key_code == KEY_CODE_4 || key_code == KEY_CODE_6))
  `TKEQ_ASSERT_IMP(a_pop_when_spent, clk, rst, pop, (work == '0) && head.valid)
  `TKEQ_ASSERT_NXT(a_rest_kept, clk, rst, load && (rem != '0), (work != '0) && !m_tlast)

endmodule

FILE: rtl/touch_key_event_qualifier_top.sv
// Touch key event qualifier: poll input, APB registers, event queue and serialiser.
// An accepted poll's key codes are written into the event queue, then registered at the serialiser output.
// Throughput: one poll per cycle while the queue has room; one key code per cycle out while m_tready does not stall.
// A poll that causes n key codes (n at most 4) holds the serialiser until all n have gone out.
// Reset (rst, synchronous) clears touch state, shield and pending timers and the queue;
// shield_ms returns to 100 and confirm_delay_ms to 200.
module touch_key_event_qualifier_top import tkeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] now_ms, [39:32] status_a, [47:40] keys_a, [55:48] status_b,
  // [63:56] keys_b, [71:64] status_c, [79:72] keys_c
  input  logic [79:0]           s_tdata,
  input  logic                  s_tuser,   // key_ban
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [2:0] key_code, [7:3] zero
  output logic                  m_tlast,   // last_event
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] shield_ms;
  logic [15:0] confirm_delay_ms;
  logic        cfg_wr;
  logic        accept;
  logic        q_full;
  logic        pop;
  evt_req_t    push;
  evt_req_t    head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shield_ms        <= SHIELD_RESET;
      confirm_delay_ms <= CONFIRM_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SHIELD:  shield_ms        <= pwdata[15:0];
        REG_CONFIRM: confirm_delay_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SHIELD:  prdata = {16'd0, shield_ms};
      REG_CONFIRM: prdata = {16'd0, confirm_delay_ms};
      default:     prdata = '0;
    endcase
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  tkeq_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .now_ms           (s_tdata[31:0]),
    .key_ban          (s_tuser),
    .status_a         (s_tdata[39:32]),
    .keys_a           (s_tdata[47:40]),
    .status_b         (s_tdata[55:48]),
    .keys_b           (s_tdata[63:56]),
    .status_c         (s_tdata[71:64]),
    .keys_c           (s_tdata[79:72]),
    .shield_ms        (shield_ms),
    .confirm_delay_ms (confirm_delay_ms),
    .push             (push)
  );

  tkeq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  tkeq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/key_event_checker.sv
// Key event checker: predicts key codes from accepted polls, compares the result stream and checks register reads.
module key_event_checker import tkeq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [79:0]           s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,
  input  logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    keys_awaited
);

  localparam logic [CFG_ADDR_W-1:0] SHIELD_ADDR  = {REG_SHIELD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] CONFIRM_ADDR = {REG_CONFIRM, 2'b00};

  typedef struct packed {
    logic [2:0] key_code;
    logic       last_event;
  } key_event_t;

  key_event_t  expected_keys[$];

  logic [15:0] shield_len;
  logic [15:0] confirm_len;
  logic [5:0]  touch_prev;
  logic [31:0] shield_end;
  logic [31:0] k4_since;
  logic        k4_armed;

  function automatic logic [1:0] chip_pair(input logic [7:0] status, input logic [7:0] keys,
                                           input logic [1:0] held);
    return (status == STATUS_OK_HI || status == STATUS_OK_LO) ? keys[1:0] : held;
  endfunction

  task automatic qualify_poll(input logic [79:0] poll, input logic ban);
    logic [31:0] now;
    logic [31:0] elapsed;
    logic [5:0]  touch;
    logic [5:0]  rise;
    logic [2:0]  codes[$];
    key_event_t  ev;
    now = poll[31:0];
    if (!ban) begin
      elapsed = now - k4_since;
      // confirm or drop a waiting key four before looking at new presses
      if (k4_armed && elapsed > {16'd0, confirm_len}) begin
        if (!(shield_end > now))
          codes.push_back(KEY_CODE_4);
        k4_armed = 1'b0;
      end
      touch = {chip_pair(poll[71:64], poll[79:72], touch_prev[5:4]),
               chip_pair(poll[55:48], poll[63:56], touch_prev[3:2]),
               chip_pair(poll[39:32], poll[47:40], touch_prev[1:0])};
      rise = touch & ~touch_prev;
      if (rise[4]) begin
        shield_end = now + {16'd0, shield_len};
        k4_armed = 1'b0;
        codes.push_back(KEY_CODE_2);
      end
      if (rise[0]) begin
        shield_end = now + {16'd0, shield_len};
        k4_armed = 1'b0;
        codes.push_back(KEY_CODE_3);
      end
      if (rise[1] && !(shield_end > now)) begin
        k4_since = now;
        k4_armed = 1'b1;
      end
      if (rise[3])
        codes.push_back(KEY_CODE_6);
      touch_prev = touch;
      foreach (codes[i]) begin
        ev.key_code   = codes[i];
        ev.last_event = (i == codes.size() - 1);
        expected_keys.push_back(ev);
      end
    end
  endtask

  always @(posedge clk) begin
    key_event_t ev;
    if (rst) begin
      shield_len  = SHIELD_RESET;
      confirm_len = CONFIRM_RESET;
      touch_prev  = '0;
      shield_end  = '0;
      k4_since    = '0;
      k4_armed    = 1'b0;
      expected_keys.delete();
      mismatches  = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == SHIELD_ADDR)
            shield_len = pwdata[15:0];
          else if (paddr == CONFIRM_ADDR)
            confirm_len = pwdata[15:0];
        end else if (paddr == SHIELD_ADDR && prdata !== {16'd0, shield_len}) begin
          $display("%0t: shield_ms read expected %0d got %0d", $time, shield_len, prdata);
          mismatches++;
        end else if (paddr == CONFIRM_ADDR && prdata !== {16'd0, confirm_len}) begin
          $display("%0t: confirm_delay_ms read expected %0d got %0d", $time, confirm_len,
                   prdata);
          mismatches++;
        end
      end
      if (s_tvalid && s_tready)
        qualify_poll(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: key code expected none got %0d (last %0b)", $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          ev = expected_keys.pop_front();
          if (m_tdata !== {5'd0, ev.key_code}) begin
            $display("%0t: key_code expected %0d got %0d", $time, ev.key_code, m_tdata);
            mismatches++;
          end
          if (m_tlast !== ev.last_event) begin
            $display("%0t: last_event expected %0b got %0b", $time, ev.last_event, m_tlast);
            mismatches++;
          end
        end
      end
    end
    keys_awaited = expected_keys.size();
  end

endmodule

FILE: bench/touch_key_event_qualifier_top_tb.sv
// Testbench top: drives polls, register writes and reads and result back-pressure, and gives the verdict.
module touch_key_event_qualifier_top_tb import tkeq_pkg::*; ();

  localparam logic [CFG_ADDR_W-1:0] SHIELD_ADDR  = {REG_SHIELD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] CONFIRM_ADDR = {REG_CONFIRM, 2'b00};
  localparam int SETTLE         = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [79:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int          mismatches;
  int          keys_awaited;
  int          quiet_cycles;
  bit          send_idle;
  bit          take_idle;
  bit          hold_req;
  logic [31:0] t_now;
  logic [5:0]  finger_bits;

  touch_key_event_qualifier_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  key_event_checker u_key_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .keys_awaited (keys_awaited)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("touch_key_event_qualifier_top regression: fail");
      $finish;
    end
  end

  // Result receiver: random stalls per key code, and one long hold on request
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = take_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_poll(input logic [31:0] now, input logic ban,
                           input logic [7:0] sa, input logic [7:0] ka,
                           input logic [7:0] sb, input logic [7:0] kb,
                           input logic [7:0] sc, input logic [7:0] kc);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {kc, sc, kb, sb, ka, sa, now};
    s_tuser  <= ban;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Poll with all chips valid; only the two touch bits of each chip are given
  task automatic tap(input logic [31:0] now, input logic [1:0] a, input logic [1:0] b,
                     input logic [1:0] c);
    send_poll(now, 1'b0, STATUS_OK_HI, {6'($urandom_range(0, 63)), a},
              STATUS_OK_LO, {6'($urandom_range(0, 63)), b},
              STATUS_OK_HI, {6'($urandom_range(0, 63)), c});
  endtask

  // Setup and access phases, then the bus is left idle before it is used again
  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_status();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return STATUS_OK_HI;
    else if (r < 85)
      return STATUS_OK_LO;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input logic [15:0] shield, input logic [15:0] confirm,
                           input logic [31:0] start, input bit send_gaps,
                           input bit take_gaps, input bit squeeze, input int count);
    int step_cap;
    logic ban;
    apb_access(1'b1, SHIELD_ADDR, {16'd0, shield});
    apb_access(1'b1, CONFIRM_ADDR, {16'd0, confirm});
    apb_access(1'b0, SHIELD_ADDR, 32'd0);
    apb_access(1'b0, CONFIRM_ADDR, 32'd0);
    send_idle = send_gaps;
    take_idle = take_gaps;
    if (squeeze)
      hold_req = 1'b1;
    step_cap = 2 * ((shield > confirm) ? shield : confirm) + 40;
    t_now = start;
    repeat (count) begin
      if ($urandom_range(0, 99) < 3)
        t_now = $urandom();
      else
        t_now = t_now + $urandom_range(0, step_cap);
      for (int i = 0; i < 6; i++)
        if ($urandom_range(0, 99) < 25)
          finger_bits[i] = ~finger_bits[i];
      ban = ($urandom_range(0, 99) < 8);
      send_poll(t_now, ban,
                pick_status(), {6'($urandom_range(0, 63)), finger_bits[1:0]},
                pick_status(), {6'($urandom_range(0, 63)), finger_bits[3:2]},
                pick_status(), {6'($urandom_range(0, 63)), finger_bits[5:4]});
    end
    s_tvalid <= 1'b0;
    wait (keys_awaited == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_idle   = 1'b1;
    take_idle   = 1'b1;
    hold_req    = 1'b0;
    finger_bits = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at reset settings
    send_poll(32'h0000_0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, STATUS_OK_LO, 8'h00);
    tap(32'd1000, 2'b10, 2'b00, 2'b00);
    tap(32'd1100, 2'b00, 2'b00, 2'b00);   // release does not cancel key four
    tap(32'd1201, 2'b00, 2'b00, 2'b00);
    send_poll(32'd1300, 1'b0, STATUS_OK_HI, 8'hFF, STATUS_OK_LO, 8'hFF, STATUS_OK_HI, 8'hFF);
    send_poll(32'd1310, 1'b0, 8'h00, 8'h00, 8'hC1, 8'h00, 8'h7F, 8'h00);
    send_poll(32'd1320, 1'b1, STATUS_OK_HI, 8'h00, STATUS_OK_HI, 8'h00, STATUS_OK_HI, 8'h00);
    tap(32'd1330, 2'b00, 2'b00, 2'b00);
    send_poll(32'd1340, 1'b1, STATUS_OK_HI, 8'hFF, STATUS_OK_HI, 8'hFF, STATUS_OK_HI, 8'hFF);
    tap(32'd1500, 2'b10, 2'b00, 2'b00);
    tap(32'd1600, 2'b00, 2'b00, 2'b00);
    tap(32'd1650, 2'b10, 2'b00, 2'b00);   // repeated press restarts the wait
    tap(32'd1800, 2'b10, 2'b00, 2'b00);
    tap(32'd1851, 2'b10, 2'b00, 2'b00);
    tap(32'd2000, 2'b00, 2'b00, 2'b00);
    tap(32'd2100, 2'b10, 2'b00, 2'b00);
    tap(32'd2150, 2'b11, 2'b00, 2'b00);   // key three cancels the waiting key four
    tap(32'd2500, 2'b00, 2'b00, 2'b00);
    tap(32'd5000, 2'b01, 2'b00, 2'b00);
    tap(32'd5010, 2'b00, 2'b00, 2'b00);
    tap(32'd5200, 2'b10, 2'b00, 2'b00);
    tap(32'd5050, 2'b00, 2'b00, 2'b00);   // time steps back: shield drops key four
    tap(32'hFFFF_FFC0, 2'b01, 2'b00, 2'b00);   // shield end wraps past zero
    tap(32'hFFFF_FFF0, 2'b10, 2'b00, 2'b00);
    tap(32'h0000_0100, 2'b00, 2'b00, 2'b00);
    send_poll(32'hFFFF_FFFF, 1'b0, STATUS_OK_LO, 8'hFC, STATUS_OK_LO, 8'hFE,
              STATUS_OK_LO, 8'h01);
    s_tvalid <= 1'b0;
    wait (keys_awaited == 0);
    repeat (SETTLE) @(negedge clk);
    finger_bits = '0;

    run_phase(16'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, 40);
    run_phase(16'hFFFF, 16'hFFFF, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 40);
    run_phase(SHIELD_RESET, CONFIRM_RESET, 32'd7000, 1'b0, 1'b1, 1'b1, 40);
    run_phase(16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)),
              $urandom(), 1'b1, 1'b1, 1'b0, 40);
    run_phase(16'd0, 16'hFFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 40);
    run_phase(16'hFFFF, 16'd0, 32'hFFFF_FF00, 1'b1, 1'b1, 1'b0, 40);

    if (mismatches == 0)
      $display("touch_key_event_qualifier_top regression: pass");
    else
      $display("touch_key_event_qualifier_top regression: fail");
    $finish;
  end

endmodule

FILE: touch_key_event_qualifier_top.f
+incdir+rtl
rtl/tkeq_pkg.sv
rtl/tkeq_front.sv
rtl/tkeq_fifo.sv
rtl/tkeq_back.sv
rtl/touch_key_event_qualifier_top.sv
bench/key_event_checker.sv
bench/touch_key_event_qualifier_top_tb.sv
